### sv/erm_pkg.sv
// Package: shared types, constants and CORDIC arctangent table for the rotation matrix block.
package erm_pkg;

  localparam int INNER_FRAC = 30;
  localparam logic signed [33:0] CORDIC_ONE = 34'sd652032874;
  localparam int FIELD_W = 16;

  typedef logic signed [FIELD_W-1:0] field_t;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_item_t;

  // CORDIC working vector: x, y in Q2.30 plus guard, residual angle in 2^-32 turn.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cvec_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t;
    begin
      case (i)
        0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
        3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
        6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
        9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
        12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
        15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
        18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
        21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
        24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
        27: t = 32'd5;         28: t = 32'd3;         29: t = 32'd1;
        30: t = 32'd1;         default: t = 32'd0;
      endcase
      return t;
    end
  endfunction

endpackage

### sv/erm_if.sv
// Interface: valid/ready channel carrying one payload item.
interface erm_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/erm_cordic_cell.sv
// One CORDIC micro-rotation cell; three lanes (x, y, z angles) advance together.
module erm_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           en,
  input  erm_pkg::cvec_t vin [3],
  input  logic [1:0]     qin [3],
  output erm_pkg::cvec_t vout_r [3],
  output logic [1:0]     qout_r [3]
);
  import erm_pkg::*;

  localparam logic signed [33:0] TAB = $signed({2'b00, atan_turn(STAGE)});

  cvec_t vout_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!vin[k].z[33]) begin
        vout_nxt[k].x = vin[k].x - (vin[k].y >>> STAGE);
        vout_nxt[k].y = vin[k].y + (vin[k].x >>> STAGE);
        vout_nxt[k].z = vin[k].z - TAB;
      end else begin
        vout_nxt[k].x = vin[k].x + (vin[k].y >>> STAGE);
        vout_nxt[k].y = vin[k].y - (vin[k].x >>> STAGE);
        vout_nxt[k].z = vin[k].z + TAB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vout_r <= vout_nxt;
      qout_r <= qin;
    end
  end
endmodule

### sv/erm_matrix.sv
// Matrix builder: quadrant fix-up, coefficient rounding, products and sums over four stages.
module erm_matrix #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic [3:0]         en,
  input  erm_pkg::cvec_t     vin [3],
  input  logic [1:0]         qin [3],
  output erm_pkg::out_item_t mat_r
);
  import erm_pkg::*;

  localparam int F  = COEF_FRAC_BITS;
  localparam int SH = INNER_FRAC - F;
  // Coefficients and first-level products stay within +-1.0, so F + 2 bits hold them.
  localparam int CW = F + 2;
  localparam logic signed [33:0] ONE34 = 34'sd1 <<< F;
  localparam logic signed [35:0] ONE36 = 36'sd1 <<< F;
  localparam logic signed [2*CW-1:0] HALF = (2*CW)'(1) <<< (F - 1);

  typedef logic signed [33:0] c_t;

  function automatic c_t to_coef(input c_t v);
    c_t t;
    begin
      if (SH == 0) t = v;
      else t = (v + (c_t'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
      if (t > ONE34) t = ONE34;
      else if (t < -ONE34) t = -ONE34;
      return t;
    end
  endfunction

  function automatic c_t prod(input c_t a, input c_t b);
    logic signed [CW-1:0]   an;
    logic signed [CW-1:0]   bn;
    logic signed [2*CW-1:0] p;
    begin
      an = a[CW-1:0];
      bn = b[CW-1:0];
      p = (an * bn + HALF) >>> F;
      return c_t'(p);
    end
  endfunction

  function automatic logic signed [15:0] sat(input logic signed [35:0] v);
    logic signed [35:0] t;
    begin
      t = v;
      if (t > ONE36) t = ONE36;
      else if (t < -ONE36) t = -ONE36;
      return t[15:0];
    end
  endfunction

  c_t cs_nxt [3], sn_nxt [3];
  c_t cs_r [3], sn_r [3];

  // Stage A: quadrant fix-up and rounding to coefficient.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (qin[k])
        2'd0: begin cs_nxt[k] = to_coef(vin[k].x);  sn_nxt[k] = to_coef(vin[k].y);  end
        2'd1: begin cs_nxt[k] = to_coef(-vin[k].y); sn_nxt[k] = to_coef(vin[k].x);  end
        2'd2: begin cs_nxt[k] = to_coef(-vin[k].x); sn_nxt[k] = to_coef(-vin[k].y); end
        default: begin cs_nxt[k] = to_coef(vin[k].y); sn_nxt[k] = to_coef(-vin[k].x); end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cs_r <= cs_nxt;
      sn_r <= sn_nxt;
    end
  end

  // Stage B: first-level products.
  c_t czsy_r, szsy_r, m00_r, m10_r, szcx_r, szsx_r, czcx_r, czsx_r, m21_r, m22_r, nsy_r;
  c_t sx_b_r, cx_b_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      czsy_r <= prod(cs_r[2], sn_r[1]);
      szsy_r <= prod(sn_r[2], sn_r[1]);
      m00_r  <= prod(cs_r[2], cs_r[1]);
      m10_r  <= prod(sn_r[2], cs_r[1]);
      szcx_r <= prod(sn_r[2], cs_r[0]);
      szsx_r <= prod(sn_r[2], sn_r[0]);
      czcx_r <= prod(cs_r[2], cs_r[0]);
      czsx_r <= prod(cs_r[2], sn_r[0]);
      m21_r  <= prod(cs_r[1], sn_r[0]);
      m22_r  <= prod(cs_r[1], cs_r[0]);
      nsy_r  <= -sn_r[1];
      sx_b_r <= sn_r[0];
      cx_b_r <= cs_r[0];
    end
  end

  // Stage C: second-level products.
  c_t a01_r, a02_r, a11_r, a12_r;
  c_t szcx_c_r, szsx_c_r, czcx_c_r, czsx_c_r, m00_c_r, m10_c_r, m20_c_r, m21_c_r, m22_c_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a01_r    <= prod(czsy_r, sx_b_r);
      a02_r    <= prod(czsy_r, cx_b_r);
      a11_r    <= prod(szsy_r, sx_b_r);
      a12_r    <= prod(szsy_r, cx_b_r);
      szcx_c_r <= szcx_r;
      szsx_c_r <= szsx_r;
      czcx_c_r <= czcx_r;
      czsx_c_r <= czsx_r;
      m00_c_r  <= m00_r;
      m10_c_r  <= m10_r;
      m20_c_r  <= nsy_r;
      m21_c_r  <= m21_r;
      m22_c_r  <= m22_r;
    end
  end

  // Stage D: sums and saturation.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      mat_r.m00 <= sat(36'(m00_c_r));
      mat_r.m01 <= sat(36'(a01_r) - 36'(szcx_c_r));
      mat_r.m02 <= sat(36'(a02_r) + 36'(szsx_c_r));
      mat_r.m10 <= sat(36'(m10_c_r));
      mat_r.m11 <= sat(36'(a11_r) + 36'(czcx_c_r));
      mat_r.m12 <= sat(36'(a12_r) - 36'(czsx_c_r));
      mat_r.m20 <= sat(36'(m20_c_r));
      mat_r.m21 <= sat(36'(m21_c_r));
      mat_r.m22 <= sat(36'(m22_c_r));
    end
  end
endmodule

### sv/euler_rotation_matrix_top.sv
// Top level: Euler angles (Z-Y-X) to 3x3 rotation matrix, CORDIC chain plus product stages.
// Throughput: one item per cycle; the chain of CORDIC cells and the four matrix
//   stages form one pipeline that advances whenever the last stage can move on.
// Reset: synchronous active-low rst_n clears the stage valid bits only; payload
//   registers are not reset.
module euler_rotation_matrix_top #(
  parameter int ANGLE_BITS     = 16,
  parameter int COEF_FRAC_BITS = 14,
  parameter int CORDIC_STAGES  = 16
) (
  input logic clk,
  input logic rst_n,
  erm_if.sink   in_ch,
  erm_if.source out_ch
);
  import erm_pkg::*;

  // Stage count capped at 32; a stage past the last table entry runs with a zero arctangent.
  localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  // Stages: 1 entry + NST cells + 4 matrix stages; out register is the last matrix stage.
  localparam int NV  = NST + 5;

  in_item_t in_d;
  assign in_d = in_ch.data;

  // Pipeline valid bits and global advance: the whole chain moves when the
  // output stage is empty or being taken, or it holds.
  logic [NV-1:0] vld_r, vld_nxt;
  logic adv;
  assign adv = !vld_r[NV-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    vld_nxt = vld_r;
    if (adv) vld_nxt = {vld_r[NV-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

  // Entry stage: place the angle in a 32-bit turn, split off the quadrant.
  cvec_t         v0_r [3];
  logic [1:0]    q0_r [3];
  logic [ANGLE_BITS-1:0] raw [3];
  logic [31:0]   phase [3];
  logic [1:0]    qd [3];
  logic [31:0]   resid [3];

  assign raw[0] = ANGLE_BITS'(in_d.angle_x);
  assign raw[1] = ANGLE_BITS'(in_d.angle_y);
  assign raw[2] = ANGLE_BITS'(in_d.angle_z);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      phase[k] = 32'({raw[k], {(32 - ANGLE_BITS + 1){1'b0}}} >> 1);
      qd[k]    = 2'((phase[k] + 32'h2000_0000) >> 30);
      resid[k] = phase[k] - {qd[k], 30'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        v0_r[k].x <= CORDIC_ONE;
        v0_r[k].y <= '0;
        v0_r[k].z <= 34'($signed(resid[k]));
        q0_r[k]   <= qd[k];
      end
    end
  end

  // Chain of CORDIC cells, each handing its vector to the next whenever the chain advances.
  cvec_t      cv [NST+1][3];
  logic [1:0] cq [NST+1][3];
  assign cv[0] = v0_r;
  assign cq[0] = q0_r;

  for (genvar s = 0; s < NST; s++) begin : g_cell
    erm_cordic_cell #(.STAGE(s)) u_cell (
      .clk    (clk),
      .en     (adv),
      .vin    (cv[s]),
      .qin    (cq[s]),
      .vout_r (cv[s+1]),
      .qout_r (cq[s+1])
    );
  end

  out_item_t mat;

  erm_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_matrix (
    .clk   (clk),
    .en    ({4{adv}}),
    .vin   (cv[NST]),
    .qin   (cq[NST]),
    .mat_r (mat)
  );

  assign out_ch.valid = vld_r[NV-1];
  assign out_ch.data  = mat;

  // A stalled result must hold its valid.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");

  // Input accepted exactly when chain advances.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("ready out of step with output stage");

  // Accepted item enters the pipeline.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted item lost at entry");
endmodule
